// ----- src/tlfq_pkg.sv -----
// ----------------------------------------------------------------------------
// tlfq_pkg: shared types and constants of the feedback queue scheduler
// Holds the process count, field widths, event codes and the
// controller-to-datapath command and datapath-to-controller status structs.
// ----------------------------------------------------------------------------
package tlfq_pkg;

    localparam int NumProc = 8;
    localparam int IdxW    = $clog2(NumProc);
    localparam int CntW    = $clog2(NumProc + 1);

    localparam logic [15:0] Max16 = 16'hFFFF;
    localparam logic [7:0]  QuantumTopReset    = 8'd5;
    localparam logic [7:0]  QuantumMiddleReset = 8'd10;

    typedef enum logic [2:0] {
        EV_IDLE     = 3'd0,
        EV_NEED     = 3'd1,
        EV_DEMOTE   = 3'd2,
        EV_IO_WAIT  = 3'd3,
        EV_COMPLETE = 3'd4,
        EV_ALL_DONE = 3'd5
    } t_event;

    typedef enum logic [0:0] {
        OP_ADVANCE = 1'b0,
        OP_BURST   = 1'b1
    } t_op;

    typedef enum logic [0:0] {
        CFG_QUANTUM_TOP    = 1'b0,
        CFG_QUANTUM_MIDDLE = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_APPLY,
        ST_OUT
    } t_state;

    // Command from controller to datapath.
    typedef struct packed {
        logic load_in;     // capture the input beat
        logic scan_clr;    // start a selection scan
        logic scan_step;   // examine one slot
        logic decide;      // pick the action and write the state
        logic out_load;    // load the result register; unused, decide loads it
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic scan_last;   // the slot being examined is the last one
        logic skip;        // a burst beat with nothing pending
    } t_stat;

    function automatic logic [15:0] sat16(input logic [17:0] v);
        return (v > {2'b00, Max16}) ? Max16 : v[15:0];
    endfunction

endpackage

// ----- src/tlfq_datapath.sv -----
// ----------------------------------------------------------------------------
// tlfq_datapath: process table, selection scan and slice arithmetic
// Scans one slot per cycle for the best ready process, then applies the
// scheduling action and forms the result beat.
// ----------------------------------------------------------------------------
module tlfq_datapath import tlfq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_op,
    input  logic [9:0]  i_cpu,
    input  logic [9:0]  i_io,
    output logic [2:0]  o_event,
    output logic [2:0]  o_id,
    output logic [1:0]  o_level,
    output logic [15:0] o_now,
    output logic [9:0]  o_left,
    output logic [15:0] o_turn,
    output logic [16:0] o_wait,
    output logic [15:0] o_idle
);

    logic [7:0]  r_qtop, r_qmid;
    logic [1:0]  r_level  [NumProc];
    logic [9:0]  r_left   [NumProc];
    logic [15:0] r_ready  [NumProc];
    logic [15:0] r_btot   [NumProc];
    logic [19:0] r_cpuio  [NumProc];
    logic [NumProc-1:0] r_done;
    logic [15:0] r_now, r_idle;
    logic [CntW-1:0] r_dcnt;
    logic        r_pend;
    logic [IdxW-1:0] r_pidx;

    logic        r_op;
    logic [9:0]  r_cpu, r_io;
    logic [IdxW-1:0] r_sidx, r_best;
    logic        r_found;

    logic [2:0]  r_ev;
    logic [2:0]  r_oid;
    logic [1:0]  r_olev;
    logic [9:0]  r_oleft;
    logic [15:0] r_oturn;
    logic [16:0] r_owait;

    logic cand, better;

    assign cand   = !r_done[r_sidx] && (r_ready[r_sidx] <= r_now);
    assign better = !r_found || (r_level[r_sidx] < r_level[r_best]) ||
                    ((r_level[r_sidx] == r_level[r_best]) &&
                     (r_ready[r_sidx] < r_ready[r_best]));

    assign o_stat.scan_last = (r_sidx == IdxW'(NumProc - 1));
    assign o_stat.skip      = (r_op == OP_BURST) && !r_pend;

    // Decision logic on the chosen slot.
    logic [IdxW-1:0] w_i;
    logic [1:0]  w_lv;
    logic [9:0]  w_amt;
    logic [9:0]  w_qx;
    logic        w_dem;
    logic [9:0]  w_cpu_s, w_io_s;
    logic [15:0] w_now_d, w_now_f;
    logic [15:0] w_btot;

    always_comb begin
        w_i  = (r_op == OP_BURST) ? r_pidx : r_best;
        w_lv = r_level[w_i];
        w_amt = (r_op == OP_BURST) ? r_cpu : r_left[w_i];
        w_dem = 1'b0;
        w_qx  = {2'b00, r_qmid};
        if (r_op == OP_BURST) begin
            if (w_lv == 2'd1 && r_cpu > {2'b00, r_qtop}) begin
                w_dem = 1'b1;
                w_qx  = {2'b00, r_qtop};
            end else if (w_lv == 2'd2 && r_cpu > {2'b00, r_qmid}) begin
                w_dem = 1'b1;
            end
            w_cpu_s = r_cpu;
            w_io_s  = r_io;
        end else begin
            w_dem   = (w_lv == 2'd2) && (r_left[w_i] > {2'b00, r_qmid});
            w_cpu_s = r_cpuio[w_i][9:0];
            w_io_s  = r_cpuio[w_i][19:10];
        end
        w_now_d = sat16({2'b00, r_now} + {8'd0, w_qx});
        w_now_f = sat16({2'b00, r_now} + {8'd0, w_amt});
        w_btot  = sat16({2'b00, r_btot[w_i]} + {8'd0, w_cpu_s} + {8'd0, w_io_s});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qtop <= QuantumTopReset;
            r_qmid <= QuantumMiddleReset;
            for (int k = 0; k < NumProc; k++) begin
                r_level[k] <= 2'd1;
                r_left[k]  <= '0;
                r_ready[k] <= '0;
                r_btot[k]  <= '0;
            end
            r_done  <= '0;
            r_now   <= '0;
            r_idle  <= '0;
            r_dcnt  <= '0;
            r_pend  <= 1'b0;
            r_pidx  <= '0;
            r_found <= 1'b0;
            r_sidx  <= '0;
            r_best  <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_QUANTUM_TOP) r_qtop <= i_cfg_data;
                else                              r_qmid <= i_cfg_data;
            end
            if (i_cmd.scan_clr) begin
                r_sidx  <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (cand && better) begin
                    r_best  <= r_sidx;
                    r_found <= 1'b1;
                end
                if (!o_stat.scan_last) r_sidx <= r_sidx + 1'b1;
            end
            if (i_cmd.decide) begin
                if (r_op == OP_ADVANCE && r_pend) begin
                    r_ev    <= EV_NEED;
                    r_oid   <= 3'(r_pidx);
                    r_olev  <= r_level[r_pidx];
                    r_oleft <= r_left[r_pidx];
                    r_oturn <= '0;
                    r_owait <= '0;
                end else if (r_op == OP_ADVANCE && r_dcnt >= CntW'(NumProc)) begin
                    r_ev <= EV_ALL_DONE;
                    r_oid <= '0; r_olev <= 2'd1; r_oleft <= '0;
                    r_oturn <= '0; r_owait <= '0;
                end else if (r_op == OP_ADVANCE && !r_found) begin
                    r_ev <= EV_IDLE;
                    r_oid <= '0; r_olev <= 2'd1; r_oleft <= '0;
                    r_oturn <= '0; r_owait <= '0;
                    r_now  <= sat16({2'b00, r_now} + 18'd1);
                    r_idle <= sat16({2'b00, r_idle} + 18'd1);
                end else if (r_op == OP_ADVANCE && r_left[w_i] == '0) begin
                    r_ev    <= EV_NEED;
                    r_oid   <= 3'(w_i);
                    r_pend  <= 1'b1;
                    r_pidx  <= w_i;
                    r_olev  <= w_lv;
                    r_oleft <= '0;
                    r_oturn <= '0;
                    r_owait <= '0;
                end else begin
                    r_oid <= 3'(w_i);
                    if (r_op == OP_BURST) begin
                        r_pend     <= 1'b0;
                        r_cpuio[w_i] <= {r_io, r_cpu};
                    end
                    if (w_dem) begin
                        r_ev         <= EV_DEMOTE;
                        r_now        <= w_now_d;
                        r_left[w_i]  <= w_amt - w_qx;
                        r_level[w_i] <= w_lv + 2'd1;
                        r_ready[w_i] <= sat16({2'b00, w_now_d} + {8'd0, w_qx});
                        r_olev       <= w_lv + 2'd1;
                        r_oleft      <= w_amt - w_qx;
                        r_oturn      <= '0;
                        r_owait      <= '0;
                    end else begin
                        r_btot[w_i]  <= w_btot;
                        r_ready[w_i] <= sat16({2'b00, r_now} + {8'd0, w_amt} +
                                              {8'd0, w_io_s});
                        r_now        <= w_now_f;
                        r_left[w_i]  <= '0;
                        r_olev       <= w_lv;
                        r_oleft      <= '0;
                        if (w_io_s == '0) begin
                            r_ev       <= EV_COMPLETE;
                            r_done[w_i] <= 1'b1;
                            r_dcnt     <= r_dcnt + 1'b1;
                            r_oturn    <= w_now_f;
                            r_owait    <= {1'b0, w_now_f} - {1'b0, w_btot};
                        end else begin
                            r_ev    <= EV_IO_WAIT;
                            r_oturn <= '0;
                            r_owait <= '0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op  <= i_op;
            r_cpu <= i_cpu;
            r_io  <= i_io;
        end
    end

    assign o_event = r_ev;
    assign o_id    = r_oid;
    assign o_level = r_olev;
    assign o_now   = r_now;
    assign o_left  = r_oleft;
    assign o_turn  = r_oturn;
    assign o_wait  = r_owait;
    assign o_idle  = r_idle;

endmodule

// ----- src/tlfq_ctrl.sv -----
// ----------------------------------------------------------------------------
// tlfq_ctrl: sequencing of one scheduling decision
// Accepts a beat, runs the slot scan, applies the action and holds the result
// until downstream takes it; a burst beat with nothing pending gets no result.
// ----------------------------------------------------------------------------
module tlfq_ctrl import tlfq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in  = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.skip) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    if (i_stat.scan_last) n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ----- src/three_level_feedback_queue_scheduler.sv -----
// ----------------------------------------------------------------------------
// three_level_feedback_queue_scheduler: top level
// Three-level feedback queue scheduler over a fixed table of processes.
// ----------------------------------------------------------------------------
// Each input beat yields at most one result beat. A decision runs the
// selection scan, which examines one process slot per cycle, then a
// decide state that applies the action, and then offers the result until
// it is taken; the next beat is accepted only after that. A burst beat
// with no process waiting for a burst produces no result and frees the
// input after the scan state. One beat is in work at a time. The user
// must see that configuration is written only while the block is idle;
// the block itself does not enforce it.
module three_level_feedback_queue_scheduler import tlfq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // cpu_burst[9:0], io_burst[19:10], zero fill
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata    // event_res, proc_id, level, now_time,
                                        // leftover, turnaround, wait_time,
                                        // idle_total, zero fill
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic [2:0]  w_ev, w_id;
    logic [1:0]  w_lv;
    logic [15:0] w_now, w_turn, w_idle;
    logic [9:0]  w_left;
    logic [16:0] w_wait;

    tlfq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    tlfq_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .o_stat(w_stat),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_op(s_axis_tuser), .i_cpu(s_axis_tdata[9:0]), .i_io(s_axis_tdata[19:10]),
        .o_event(w_ev), .o_id(w_id), .o_level(w_lv), .o_now(w_now),
        .o_left(w_left), .o_turn(w_turn), .o_wait(w_wait), .o_idle(w_idle)
    );

    assign m_axis_tdata = {5'b00000, w_idle, w_wait, w_turn, w_left, w_now,
                           w_lv, w_id, w_ev};

    // A result is never offered while a new beat can be taken.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("result and input ready overlap");

    // An accepted beat is never followed by a result in the next cycle.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result too early");

    // The result holds while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed under stall");

endmodule
